[rtl/core/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasterizer: field widths,
// fixed-point formats, the reset color and the front-end state encoding.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_W       = 16;   // input endpoint coordinate width
    localparam int PIX_W         = 6;    // output pixel coordinate width
    localparam int COLOR_W       = 32;   // color width
    localparam int STEPS_W       = 8;    // step count width
    localparam int INC_FRAC_BITS = 16;   // fractional bits of position and increment
    localparam int STEP_W        = 18;   // signed increment width
    localparam int DELTA_W       = 17;   // signed endpoint difference width
    localparam int DMAG_W        = 16;   // magnitude of a difference
    localparam int QUOT_W        = 17;   // increment magnitude, up to exactly 1.0
    localparam int DIV_CNT_W     = 5;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'h00FF00FF;

    // One whole pixel in the increment format; the major axis steps by this.
    localparam logic [STEP_W-1:0] STEP_ONE = 18'h10000;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

endpackage

[rtl/core/dda_front.sv]
// ----------------------------------------------------------------------------
// dda_front
// Accepts a line, classifies it (dropped when it is too short or starts off
// the canvas), works out the minor-axis increment with a one-bit-per-cycle
// restoring divider and hands the finished line command to the queue.
// ----------------------------------------------------------------------------
module dda_front #(
    parameter int CANVAS_SIZE     = 64,
    parameter int COORD_FRAC_BITS = 8,
    parameter int POS_W           = 25,
    parameter int CMD_W           = 2 * POS_W + 2 * dda_pkg::STEP_W + dda_pkg::STEPS_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [dda_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [dda_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [dda_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [dda_pkg::COORD_W-1:0] i_end_y,
    output logic                               o_cmd_valid,
    input  logic                               i_cmd_ready,
    output logic [CMD_W-1:0]                   o_cmd
);

    localparam int POS_SHIFT = dda_pkg::INC_FRAC_BITS - COORD_FRAC_BITS;
    localparam logic [POS_W-1:0] LIMIT = POS_W'(CANVAS_SIZE) << dda_pkg::INC_FRAC_BITS;
    localparam logic [dda_pkg::DIV_CNT_W-1:0] DIV_LAST_BIT =
        dda_pkg::DIV_CNT_W'(dda_pkg::QUOT_W - 1);

    typedef struct packed {
        logic [POS_W-1:0]            pos_x;
        logic [POS_W-1:0]            pos_y;
        logic [dda_pkg::STEP_W-1:0]  step_x;
        logic [dda_pkg::STEP_W-1:0]  step_y;
        logic [dda_pkg::STEPS_W-1:0] steps;
    } t_line_cmd;

    function automatic logic in_canvas(input logic [POS_W-1:0] p);
        return !p[POS_W-1] && (p < LIMIT);
    endfunction

    dda_pkg::t_front_state r_state, n_state;

    logic [POS_W-1:0]             r_pos_x, r_pos_y;
    logic [dda_pkg::STEPS_W-1:0]  r_steps;
    logic                         r_major_x, r_major_neg, r_minor_neg;
    logic [dda_pkg::DMAG_W-1:0]   r_divisor;
    logic [dda_pkg::QUOT_W-1:0]   r_rem, n_rem;
    logic [dda_pkg::QUOT_W-1:0]   r_quot;
    logic [dda_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [dda_pkg::DELTA_W-1:0]  dx, dy, adx, ady;
    logic [dda_pkg::DMAG_W-1:0]   dmax, dmin;
    logic                         major_x;
    logic [dda_pkg::STEPS_W-1:0]  steps;
    logic [POS_W-1:0]             start_x, start_y;
    logic                         keep;
    logic                         accept;
    logic                         ge;
    logic [dda_pkg::QUOT_W-1:0]   diff, rem_keep;
    logic [dda_pkg::STEP_W-1:0]   minor_mag, minor_step, major_step;
    t_line_cmd                    cmd;

    // Classification of the line on the input ports.
    always_comb begin
        dx      = {i_end_x[dda_pkg::COORD_W-1], i_end_x}
                - {i_start_x[dda_pkg::COORD_W-1], i_start_x};
        dy      = {i_end_y[dda_pkg::COORD_W-1], i_end_y}
                - {i_start_y[dda_pkg::COORD_W-1], i_start_y};
        adx     = dx[dda_pkg::DELTA_W-1] ? (~dx + 1'b1) : dx;
        ady     = dy[dda_pkg::DELTA_W-1] ? (~dy + 1'b1) : dy;
        major_x = adx >= ady;
        dmax    = major_x ? adx[dda_pkg::DMAG_W-1:0] : ady[dda_pkg::DMAG_W-1:0];
        dmin    = major_x ? ady[dda_pkg::DMAG_W-1:0] : adx[dda_pkg::DMAG_W-1:0];
        steps   = dda_pkg::STEPS_W'(dmax >> COORD_FRAC_BITS);
        start_x = {{(POS_W - dda_pkg::COORD_W){i_start_x[dda_pkg::COORD_W-1]}}, i_start_x}
                  << POS_SHIFT;
        start_y = {{(POS_W - dda_pkg::COORD_W){i_start_y[dda_pkg::COORD_W-1]}}, i_start_y}
                  << POS_SHIFT;
        keep    = (steps != '0) && in_canvas(start_x) && in_canvas(start_y);
    end

    assign o_ready = (r_state == dda_pkg::F_IDLE);
    assign accept  = i_valid && o_ready;

    // Restoring division: increment = minor * 2^16 / dmax, one quotient bit a cycle.
    always_comb begin
        ge       = r_rem >= {1'b0, r_divisor};
        diff     = r_rem - {1'b0, r_divisor};
        rem_keep = ge ? diff : r_rem;
        n_rem    = {rem_keep[dda_pkg::QUOT_W-2:0], 1'b0};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dda_pkg::F_IDLE: begin
                if (accept && keep) begin
                    n_state = dda_pkg::F_DIV;
                end
            end
            dda_pkg::F_DIV: begin
                if (r_cnt == '0) begin
                    n_state = dda_pkg::F_PUSH;
                end
            end
            dda_pkg::F_PUSH: begin
                if (i_cmd_ready) begin
                    n_state = dda_pkg::F_IDLE;
                end
            end
            default: n_state = dda_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dda_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos_x     <= start_x;
            r_pos_y     <= start_y;
            r_steps     <= steps;
            r_major_x   <= major_x;
            r_major_neg <= major_x ? dx[dda_pkg::DELTA_W-1] : dy[dda_pkg::DELTA_W-1];
            r_minor_neg <= major_x ? dy[dda_pkg::DELTA_W-1] : dx[dda_pkg::DELTA_W-1];
            r_divisor   <= dmax;
            r_rem       <= {1'b0, dmin};
            r_quot      <= '0;
            r_cnt       <= DIV_LAST_BIT;
        end else if (r_state == dda_pkg::F_DIV) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[dda_pkg::QUOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_comb begin
        minor_mag  = {1'b0, r_quot};
        minor_step = r_minor_neg ? (~minor_mag + 1'b1) : minor_mag;
        major_step = r_major_neg ? (~dda_pkg::STEP_ONE + 1'b1) : dda_pkg::STEP_ONE;
        cmd.pos_x  = r_pos_x;
        cmd.pos_y  = r_pos_y;
        cmd.step_x = r_major_x ? major_step : minor_step;
        cmd.step_y = r_major_x ? minor_step : major_step;
        cmd.steps  = r_steps;
    end

    assign o_cmd_valid = (r_state == dda_pkg::F_PUSH);
    assign o_cmd       = cmd;

endmodule

[rtl/core/dda_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// dda_cmd_fifo
// Small register queue of line commands between the front and back ends.
// ----------------------------------------------------------------------------
module dda_cmd_fifo #(
    parameter int WIDTH = 94,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[rtl/core/dda_back.sv]
// ----------------------------------------------------------------------------
// dda_back
// Walks one line command: emits the truncated position each cycle the output
// register is free, adds the increments, and marks the final pixel when the
// count runs out or the next position leaves the canvas.
// ----------------------------------------------------------------------------
module dda_back #(
    parameter int CANVAS_SIZE = 64,
    parameter int POS_W       = 25,
    parameter int CMD_W       = 2 * POS_W + 2 * dda_pkg::STEP_W + dda_pkg::STEPS_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  logic [CMD_W-1:0]             i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dda_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [dda_pkg::PIX_W-1:0]    o_pixel_y,
    output logic                         o_last
);

    localparam logic [POS_W-1:0] LIMIT = POS_W'(CANVAS_SIZE) << dda_pkg::INC_FRAC_BITS;

    typedef struct packed {
        logic [POS_W-1:0]            pos_x;
        logic [POS_W-1:0]            pos_y;
        logic [dda_pkg::STEP_W-1:0]  step_x;
        logic [dda_pkg::STEP_W-1:0]  step_y;
        logic [dda_pkg::STEPS_W-1:0] steps;
    } t_line_cmd;

    function automatic logic in_canvas(input logic [POS_W-1:0] p);
        return !p[POS_W-1] && (p < LIMIT);
    endfunction

    t_line_cmd                   cmd;
    logic                        r_active;
    logic [POS_W-1:0]            r_pos_x, r_pos_y;
    logic [dda_pkg::STEP_W-1:0]  r_step_x, r_step_y;
    logic [dda_pkg::STEPS_W-1:0] r_steps;
    logic                        r_out_valid, r_out_last;
    logic [dda_pkg::PIX_W-1:0]   r_out_x, r_out_y;

    logic [POS_W-1:0]            next_x, next_y;
    logic                        emit, load, last;

    assign cmd         = i_cmd;
    assign load        = !r_active && i_cmd_valid;
    assign o_cmd_ready = !r_active;
    assign emit        = r_active && (!r_out_valid || i_ready);

    always_comb begin
        next_x = r_pos_x + {{(POS_W - dda_pkg::STEP_W){r_step_x[dda_pkg::STEP_W-1]}}, r_step_x};
        next_y = r_pos_y + {{(POS_W - dda_pkg::STEP_W){r_step_y[dda_pkg::STEP_W-1]}}, r_step_y};
        last   = (r_steps == dda_pkg::STEPS_W'(1)) || !in_canvas(next_x) || !in_canvas(next_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_steps     <= '0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
                r_pos_x  <= cmd.pos_x;
                r_pos_y  <= cmd.pos_y;
                r_step_x <= cmd.step_x;
                r_step_y <= cmd.step_y;
                r_steps  <= cmd.steps;
            end else if (emit) begin
                r_pos_x <= next_x;
                r_pos_y <= next_y;
                r_steps <= r_steps - 1'b1;
                if (last) begin
                    r_active <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The position is known to be on the canvas here, so the integer bits fit.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x    <= r_pos_x[dda_pkg::INC_FRAC_BITS +: dda_pkg::PIX_W];
            r_out_y    <= r_pos_y[dda_pkg::INC_FRAC_BITS +: dda_pkg::PIX_W];
            r_out_last <= last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

endmodule

[rtl/core/dda_line_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: takes a line between two fixed-point endpoints and
// emits its pixels on a square canvas, each tagged with the programmed color.
//
//   Channel   Direction  Handshake               Payload
//   line in   input      i_valid / o_ready       i_start_x, i_start_y, i_end_x, i_end_y
//   pixel out output     o_valid / i_ready       o_pixel_x, o_pixel_y, o_color, o_last
//   config    input      i_cfg_wr_en (no wait)   i_cfg_wr_data -> pixel_color
//
// The front end accepts a line, runs the increment divider and hands the
// line to a 2-entry queue; dropped lines never enter the divider. The back
// end loads a line from the queue, then emits one pixel per cycle while the
// output is not stalled; its walk of one line overlaps with the divider of
// the next line.
// Reset is synchronous and active low; it empties the queue and the output.
// A stalled output holds its pixel and stalls the back end; the queue may still fill.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
    parameter int CANVAS_SIZE     = 64,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [dda_pkg::COLOR_W-1:0]         i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dda_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [dda_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [dda_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [dda_pkg::COORD_W-1:0]  i_end_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dda_pkg::PIX_W-1:0]           o_pixel_x,
    output logic [dda_pkg::PIX_W-1:0]           o_pixel_y,
    output logic [dda_pkg::COLOR_W-1:0]         o_color,
    output logic                                o_last
);

    // Position: sign, integer pixels past the canvas, 16 fractional bits.
    localparam int POS_BASE_W = dda_pkg::COORD_W + dda_pkg::INC_FRAC_BITS - COORD_FRAC_BITS + 1;
    localparam int POS_W      = (POS_BASE_W > 24) ? POS_BASE_W : 24;
    localparam int CMD_W      = 2 * POS_W + 2 * dda_pkg::STEP_W + dda_pkg::STEPS_W;

    logic [dda_pkg::COLOR_W-1:0] r_pixel_color;
    logic                        push_valid, push_ready, pop_valid, pop_ready;
    logic [CMD_W-1:0]            push_data, pop_data;

    // The user must write configuration only while no line is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_color <= dda_pkg::COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_pixel_color <= i_cfg_wr_data;
        end
    end

    assign o_color = r_pixel_color;

    dda_front #(
        .CANVAS_SIZE     (CANVAS_SIZE),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .POS_W           (POS_W),
        .CMD_W           (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_cmd_valid (push_valid),
        .i_cmd_ready (push_ready),
        .o_cmd       (push_data)
    );

    dda_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    dda_back #(
        .CANVAS_SIZE (CANVAS_SIZE),
        .POS_W       (POS_W),
        .CMD_W       (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd       (pop_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last)
    );

endmodule

[rtl/core/dda_chk.sv]
// ----------------------------------------------------------------------------
// dda_chk
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_chk #(
    parameter int CANVAS_SIZE = 64
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [dda_pkg::PIX_W-1:0]   o_pixel_x,
    input logic [dda_pkg::PIX_W-1:0]   o_pixel_y,
    input logic [dda_pkg::COLOR_W-1:0] o_color,
    input logic                        o_last
);

    localparam logic [dda_pkg::PIX_W:0] SIZE = (dda_pkg::PIX_W + 1)'(CANVAS_SIZE);

    // Reset empties the output register.
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output item valid after reset");

    // Reset restores the default color.
    a_reset_color: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_color == dda_pkg::COLOR_RESET))
        else $error("color not restored by reset");

    // Every pixel lies on the canvas.
    a_pixel_on_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (({1'b0, o_pixel_x} < SIZE) && ({1'b0, o_pixel_y} < SIZE)))
        else $error("pixel outside the canvas");

    // A stalled item keeps its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last)))
        else $error("stalled output item changed");

endmodule

bind dda_line_rasterizer_unit dda_chk #(
    .CANVAS_SIZE (CANVAS_SIZE)
) u_dda_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_pixel_x (o_pixel_x),
    .o_pixel_y (o_pixel_y),
    .o_color   (o_color),
    .o_last    (o_last)
);
